FILE: rtl/core/wbs_pkg.sv
`timescale 1ns / 1ps

package wbs_pkg;

  localparam int MaxWords   = 16;
  localparam int MaxWordLen = 16;
  localparam int ByteW      = 8;
  localparam int CountW     = 5;
  localparam int SlotW      = $clog2(MaxWords);
  localparam int PosW       = $clog2(MaxWordLen);
  localparam int LenW       = $clog2(MaxWordLen + 1);
  localparam int UsedW      = $clog2(MaxWords + 1);
  localparam int RowW       = MaxWordLen * ByteW;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TEXT = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } scan_state_e;

  typedef struct packed {
    logic valid;
    logic breakable;
    logic end_of_text;
  } scan_res_t;

  typedef struct packed {
    logic            we;
    logic [SlotW-1:0] slot;
    logic [LenW-1:0]  len;
  } len_wr_t;

endpackage

FILE: rtl/core/wbs_dict_mem.sv
`timescale 1ns / 1ps

module wbs_dict_mem (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [wbs_pkg::SlotW-1:0]  wr_slot_i,
  input  logic [wbs_pkg::PosW-1:0]   wr_pos_i,
  input  logic [wbs_pkg::ByteW-1:0]  wr_byte_i,
  input  logic                       rd_en_i,
  input  logic [wbs_pkg::SlotW-1:0]  rd_slot_i,
  output logic [wbs_pkg::RowW-1:0]   rd_row_o
);
  import wbs_pkg::*;

  // one row per word, all characters of a word side by side
  logic [RowW-1:0] dict_mem_q [MaxWords];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      dict_mem_q[wr_slot_i][wr_pos_i * ByteW +: ByteW] <= wr_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_row_o <= dict_mem_q[rd_slot_i];
    end
  end

endmodule

FILE: rtl/core/wbs_scan.sv
`timescale 1ns / 1ps

module wbs_scan (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wbs_pkg::ByteW-1:0]   char_i,
  input  logic                        last_i,
  input  logic [wbs_pkg::CountW-1:0]  word_count_i,
  input  wbs_pkg::len_wr_t            len_wr_i,
  output logic                        rd_en_o,
  output logic [wbs_pkg::SlotW-1:0]   rd_slot_o,
  input  logic [wbs_pkg::RowW-1:0]    rd_row_i,
  input  logic                        res_free_i,
  output wbs_pkg::scan_res_t          res_o,
  output logic                        busy_o
);
  import wbs_pkg::*;

  scan_state_e state_q, state_d;

  logic [LenW-1:0]   lens_q [MaxWords];
  logic [ByteW-1:0]  win_q  [MaxWordLen];
  logic [MaxWordLen-1:0] hist_q;

  logic [UsedW-1:0]  used_q, used_d;
  logic [UsedW-1:0]  iss_q;
  logic              cmp_vld_q, cmp_last_q;
  logic [SlotW-1:0]  cmp_slot_q;
  logic              ok_q, last_q;

  logic              issue;
  logic              emit_take;
  logic [LenW-1:0]   cmp_len;
  logic [PosW-1:0]   win_idx;
  logic [MaxWordLen-1:0] pos_ok;
  logic              hist_bit;
  logic              match;

  always_comb begin
    if (word_count_i > CountW'(MaxWords)) begin
      used_d = UsedW'(MaxWords);
    end else begin
      used_d = UsedW'(word_count_i);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (used_d == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cmp_vld_q && cmp_last_q) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    issue           = 1'b0;
    res_o           = '0;
    busy_o          = 1'b1;
    unique case (state_q)
      ST_IDLE: busy_o = 1'b0;
      ST_SCAN: issue  = (iss_q < used_q);
      ST_EMIT: begin
        res_o.valid       = 1'b1;
        res_o.breakable   = ok_q;
        res_o.end_of_text = last_q;
      end
      default: busy_o = 1'b1;
    endcase
  end

  assign emit_take = res_o.valid && res_free_i;
  assign rd_en_o   = issue;
  assign rd_slot_o = iss_q[SlotW-1:0];

  // compare one dictionary row against the window
  always_comb begin
    win_idx = '0;
    cmp_len = lens_q[cmp_slot_q];
    for (int p = 0; p < MaxWordLen; p++) begin
      win_idx   = PosW'(cmp_len - LenW'(p) - LenW'(1));
      pos_ok[p] = (LenW'(p) >= cmp_len) || (rd_row_i[p * ByteW +: ByteW] == win_q[win_idx]);
    end
    hist_bit = hist_q[PosW'(cmp_len - LenW'(1))];
    match    = (cmp_len != '0) && hist_bit && (&pos_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      iss_q      <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      hist_q     <= MaxWordLen'(1);
      for (int s = 0; s < MaxWords; s++) begin
        lens_q[s] <= '0;
      end
    end else begin
      state_q    <= state_d;
      cmp_vld_q  <= issue;
      cmp_last_q <= issue && ((iss_q + UsedW'(1)) == used_q);
      if (start_i) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + UsedW'(1);
      end
      if (len_wr_i.we) begin
        lens_q[len_wr_i.slot] <= len_wr_i.len;
      end
      if (emit_take) begin
        if (last_q) begin
          hist_q <= MaxWordLen'(1);
        end else begin
          hist_q <= {hist_q[MaxWordLen-2:0], ok_q};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      cmp_slot_q <= iss_q[SlotW-1:0];
    end
    if (start_i) begin
      used_q <= used_d;
      last_q <= last_i;
      ok_q   <= 1'b0;
      win_q[0] <= char_i;
      for (int k = 1; k < MaxWordLen; k++) begin
        win_q[k] <= win_q[k-1];
      end
    end else if (cmp_vld_q && match) begin
      ok_q <= 1'b1;
    end
  end

endmodule

FILE: rtl/core/word_break_segmenter_core.sv
`timescale 1ns / 1ps

// Word break segmenter. Dictionary characters (cmd 0) are written into a row
// memory, one row per word, and a word's length is taken from the character
// flagged last; a load gives no result. Each text character (cmd 1) gives
// one result telling whether the text so far splits into words from slots 0
// to min(word_count, 16)-1; with last set, the result is marked end_of_text
// and the history restarts for the next text. For a text character the
// dictionary memory is read one word row per cycle and each row is compared
// in full against the recent window. A finished result waits in an output
// register while the next request is taken. word_count must be written over
// the configuration channel only while the block is idle; the block itself
// does not enforce this. No clearing pass follows reset.
module word_break_segmenter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wbs_pkg::CountW-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [3:0]                  word_slot_i,
  input  logic [3:0]                  char_pos_i,
  input  logic [7:0]                  char_byte_i,
  input  logic                        last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        prefix_breakable_o,
  output logic                        end_of_text_o
);
  import wbs_pkg::*;

  logic [CountW-1:0] word_count_q;
  logic              in_take, load_take, text_take;
  logic              busy;
  logic              rd_en;
  logic [SlotW-1:0]  rd_slot;
  logic [RowW-1:0]   rd_row;
  logic              res_free;
  scan_res_t         res;
  len_wr_t           len_wr;
  logic              out_vld_q;
  logic              brk_q, eot_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_take     = in_valid_i && !busy;
  assign load_take   = in_take && (cmd_i == CMD_LOAD);
  assign text_take   = in_take && (cmd_i == CMD_TEXT);

  assign len_wr.we   = load_take && last_i;
  assign len_wr.slot = word_slot_i;
  assign len_wr.len  = LenW'(char_pos_i) + LenW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      word_count_q <= cfg_data_i;
    end
  end

  wbs_dict_mem u_dict_mem (
    .clk_i     (clk_i),
    .we_i      (load_take),
    .wr_slot_i (word_slot_i),
    .wr_pos_i  (char_pos_i),
    .wr_byte_i (char_byte_i),
    .rd_en_i   (rd_en),
    .rd_slot_i (rd_slot),
    .rd_row_o  (rd_row)
  );

  wbs_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (text_take),
    .char_i       (char_byte_i),
    .last_i       (last_i),
    .word_count_i (word_count_q),
    .len_wr_i     (len_wr),
    .rd_en_o      (rd_en),
    .rd_slot_o    (rd_slot),
    .rd_row_i     (rd_row),
    .res_free_i   (res_free),
    .res_o        (res),
    .busy_o       (busy)
  );

  // output register
  assign res_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_free) begin
      out_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res.valid) begin
      brk_q <= res.breakable;
      eot_q <= res.end_of_text;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign prefix_breakable_o = brk_q;
  assign end_of_text_o      = eot_q;

endmodule

FILE: tb/word_break_segmenter_core_checker.sv
`timescale 1ns / 1ps

module word_break_segmenter_core_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [wbs_pkg::CountW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic                       cmd_i,
  input  logic [3:0]                 word_slot_i,
  input  logic [3:0]                 char_pos_i,
  input  logic [7:0]                 char_byte_i,
  input  logic                       last_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       prefix_breakable_i,
  input  logic                       end_of_text_i,
  output int                         mismatch_count_o,
  output int                         pending_o
);
  import wbs_pkg::*;

  typedef struct packed {
    logic breakable;
    logic end_of_text;
  } seg_verdict_t;

  logic [ByteW-1:0]      dict_mem [MaxWords][MaxWordLen];
  logic [LenW-1:0]       word_len [MaxWords];
  logic [ByteW-1:0]      recent_chars [MaxWordLen];
  logic [MaxWordLen-1:0] split_hist;
  logic [CountW-1:0]     words_in_use;
  seg_verdict_t          verdict_q [$];
  int                    mismatches = 0;

  assign mismatch_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("checker: %s at %0t", msg, $time);
    mismatches++;
  endtask

  task automatic restart_text();
    int k;
    for (k = 0; k < MaxWordLen; k++) recent_chars[k] = '0;
    split_hist = MaxWordLen'(1);
  endtask

  // shift the char into the window and test the words in use against it until one fits
  task automatic segment_char(input logic [7:0] ch, input logic lst);
    int   k;
    int   j;
    int   p;
    int   used;
    int   len;
    logic ok;
    logic same;
    for (k = MaxWordLen - 1; k > 0; k--) recent_chars[k] = recent_chars[k-1];
    recent_chars[0] = ch;
    used = (int'(words_in_use) > MaxWords) ? MaxWords : int'(words_in_use);
    ok = 1'b0;
    for (j = 0; j < used && !ok; j++) begin
      len = int'(word_len[j]);
      if (len != 0 && split_hist[len-1]) begin
        same = 1'b1;
        for (p = 0; p < len; p++) begin
          if (dict_mem[j][p] != recent_chars[len-1-p]) same = 1'b0;
        end
        ok = same;
      end
    end
    split_hist = {split_hist[MaxWordLen-2:0], ok};
    verdict_q.push_back('{breakable: ok, end_of_text: lst});
    if (lst) restart_text();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int           s;
    int           p;
    seg_verdict_t want;
    if (!rst_ni) begin
      for (s = 0; s < MaxWords; s++) begin
        word_len[s] = '0;
        for (p = 0; p < MaxWordLen; p++) dict_mem[s][p] = '0;
      end
      words_in_use = '0;
      restart_text();
      verdict_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request waiting");
        end else begin
          want = verdict_q.pop_front();
          if (prefix_breakable_i !== want.breakable)
            report_mismatch($sformatf("prefix_breakable expected %0b got %0b",
                                      want.breakable, prefix_breakable_i));
          if (end_of_text_i !== want.end_of_text)
            report_mismatch($sformatf("end_of_text expected %0b got %0b",
                                      want.end_of_text, end_of_text_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) words_in_use = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i == CMD_TEXT) begin
          segment_char(char_byte_i, last_i);
        end else begin
          dict_mem[word_slot_i][char_pos_i] = char_byte_i;
          if (last_i) word_len[word_slot_i] = LenW'(char_pos_i) + 1'b1;
        end
      end
      pending_o <= verdict_q.size();
    end
  end

endmodule

FILE: tb/word_break_segmenter_core_tb.sv
`timescale 1ns / 1ps

module word_break_segmenter_core_tb;
  import wbs_pkg::*;

  localparam int PhaseItems  = 163;
  localparam int DrainCycles = 48;
  localparam int CycleLimit  = 600000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CountW-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  cmd_e              cmd = CMD_LOAD;
  logic [3:0]        word_slot = '0;
  logic [3:0]        char_pos = '0;
  logic [7:0]        char_byte = '0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              prefix_breakable;
  logic              end_of_text;
  int                fail_count;
  int                pending;

  int cycles = 0;
  int burst_left = 0;
  int items_sent = 0;
  int stall_left = 0;
  int stall_pct = 0;
  int count_set = 0;

  // shadow of the dictionary, used to build texts and keep lengths on written chars
  logic [7:0]            dict_chars [MaxWords][MaxWordLen];
  int                    dict_len [MaxWords] = '{default: 0};
  logic [MaxWordLen-1:0] dict_written [MaxWords] = '{default: '0};

  always #6 clk = ~clk;

  word_break_segmenter_core i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .cmd_i              (cmd),
    .word_slot_i        (word_slot),
    .char_pos_i         (char_pos),
    .char_byte_i        (char_byte),
    .last_i             (last),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .prefix_breakable_o (prefix_breakable),
    .end_of_text_o      (end_of_text)
  );

  word_break_segmenter_core_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .cmd_i              (cmd),
    .word_slot_i        (word_slot),
    .char_pos_i         (char_pos),
    .char_byte_i        (char_byte),
    .last_i             (last),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .prefix_breakable_i (prefix_breakable),
    .end_of_text_i      (end_of_text),
    .mismatch_count_o   (fail_count),
    .pending_o          (pending)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 2))
        0: stall_pct <= 0;
        1: stall_pct <= 50;
        default: stall_pct <= 80;
      endcase
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_item(input cmd_e c, input logic [3:0] slot, input logic [3:0] pos,
                           input logic [7:0] ch, input logic lst);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    cmd       <= c;
    word_slot <= slot;
    char_pos  <= pos;
    char_byte <= ch;
    last      <= lst;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  task automatic load_char(input int slot, input int pos, input logic [7:0] ch,
                           input logic lst);
    send_item(CMD_LOAD, 4'(slot), 4'(pos), ch, lst);
    dict_chars[slot][pos] = ch;
    dict_written[slot][pos] = 1'b1;
    if (lst) dict_len[slot] = pos + 1;
  endtask

  task automatic text_char(input logic [7:0] ch, input logic lst);
    send_item(CMD_TEXT, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), ch, lst);
  endtask

  // small alphabet so words match often, with a few arbitrary bytes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'h61;
    if (r < 7) return 8'h62;
    if (r < 9) return 8'h63;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic load_word(input int slot);
    int r;
    int len;
    int p;
    r = $urandom_range(0, 19);
    if (r < 13) len = $urandom_range(1, 3);
    else if (r < 18) len = $urandom_range(4, 8);
    else len = $urandom_range(9, MaxWordLen);
    for (p = 0; p < len; p++) load_char(slot, p, pick_byte(), p == len - 1);
  endtask

  // stray load; a length is only set where every covered char has been written
  task automatic noise_load();
    int                    slot;
    int                    pos;
    logic [MaxWordLen-1:0] covered;
    logic [31:0]           low;
    logic                  lst;
    slot = $urandom_range(0, MaxWords - 1);
    pos = $urandom_range(0, MaxWordLen - 1);
    covered = dict_written[slot] | (MaxWordLen'(1) << pos);
    low = (32'd1 << (pos + 1)) - 1;
    lst = ((32'(covered) & low) == low) && ($urandom_range(0, 2) == 0);
    load_char(slot, pos, 8'($urandom_range(0, 255)), lst);
  endtask

  task automatic send_sentence();
    int         used;
    int         s;
    int         n;
    int         i;
    int         j;
    int         p;
    int         cand [$];
    logic [7:0] text_q [$];
    used = (count_set > MaxWords) ? MaxWords : count_set;
    for (s = 0; s < used; s++) if (dict_len[s] > 0) cand.push_back(s);
    if (cand.size() == 0 || $urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) text_q.push_back(pick_byte());
    end else begin
      n = $urandom_range(1, 4);
      for (i = 0; i < n; i++) begin
        j = cand[$urandom_range(0, cand.size() - 1)];
        for (p = 0; p < dict_len[j]; p++) text_q.push_back(dict_chars[j][p]);
      end
      if ($urandom_range(0, 5) == 0)
        text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) text_q.push_front(pick_byte());
    end
    for (i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 39) == 0) load_word($urandom_range(0, MaxWords - 1));
      text_char(text_q[i], i == text_q.size() - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_count(input int v);
    cfg_data  <= CountW'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    count_set = v;
  endtask

  initial begin
    int phase_vals [12];
    int ph;
    int s;
    int start_cnt;
    int r;
    phase_vals = '{16, 0, 1, 31, 16, 8, 17, 0, 16, 2, 0, 16};
    phase_vals[7] = $urandom_range(0, 31);
    phase_vals[10] = $urandom_range(0, 31);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no words in use
    write_count(0);
    text_char(8'h61, 1'b1);
    load_char(0, 0, 8'h61, 1'b1);
    load_char(1, 0, 8'h62, 1'b0);
    load_char(1, 1, 8'h63, 1'b1);
    text_char(8'h61, 1'b1);

    // two words, one longer than the text, reload in the middle of a text
    wait_idle();
    write_count(2);
    text_char(8'h61, 1'b0);
    text_char(8'h62, 1'b0);
    text_char(8'h63, 1'b1);
    text_char(8'h63, 1'b1);
    text_char(8'h61, 1'b0);
    load_char(0, 0, 8'h63, 1'b1);
    text_char(8'h63, 1'b1);

    // count above the slot total, empty slots in between
    wait_idle();
    write_count(31);
    load_char(15, 0, 8'hFF, 1'b1);
    load_char(15, 15, 8'h00, 1'b0);
    text_char(8'hFF, 1'b1);
    text_char(8'h00, 1'b1);

    for (s = 0; s < MaxWords; s++) load_word(s);

    for (ph = 0; ph < 12; ph++) begin
      wait_idle();
      write_count(phase_vals[ph]);
      start_cnt = items_sent;
      while (items_sent - start_cnt < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 8) load_word($urandom_range(0, MaxWords - 1));
        else if (r < 14) noise_load();
        else send_sentence();
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
